@@ src/ddo_pkg.sv @@
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_TAB_LEN   = 24;
  localparam int DIV_ITERS        = 48;
  localparam int CNT_W            = 6;

  localparam logic [10:0]        HALF_AXLE_RST = 11'd150;
  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
  localparam logic signed [34:0] RAD2BAM       = 35'sd683565276;
  localparam logic [31:0]        US_HALF       = 32'd500000;
  // 10^6 = 2^6 * 15625; ceil(2^45 / 15625), exact for dividends below 2^31
  localparam logic [31:0]        RCP_15625     = 32'd2251799814;

  // arctan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [2:0] {
    MUL_RATE, MUL_YAW, MUL_VX, MUL_VY, MUL_PX, MUL_PY
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_RATE, WB_YAW, WB_VX, WB_VY, WB_X, WB_Y
  } wb_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_MUL, ST_R_LD, ST_R_DIV, ST_R_WB,
    ST_W_MUL, ST_W_LD, ST_W_DIV, ST_W_WB,
    ST_C_INIT, ST_C_ITER, ST_C_FIX,
    ST_VX_MUL, ST_VX_WB, ST_VY_MUL, ST_VY_WB,
    ST_X_MUL, ST_X_LD, ST_X_DIV, ST_X_WB,
    ST_Y_MUL, ST_Y_LD, ST_Y_DIV, ST_Y_WB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       div_load;
    logic       div_rate;
    logic       div_step;
    logic       rcp_step;
    wb_sel_t    wb_sel;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] cordic_idx;
    logic       cordic_fix;
    logic       emit;
  } dp_cmd_t;

endpackage

@@ src/diff_drive_odometry_unit.sv @@
// An update runs the rate divider, the heading update, the CORDIC iterations
// and the velocity and position steps; set-pose goes straight to finish.
// Throughput: one transaction at a time, the next accepted the cycle after the
// result is written; set by the 48-step rate divider and the CORDIC iterations.
// Reset (synchronous, active low) clears pose and sets half axle to 150 mm.
module diff_drive_odometry_unit import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  input  logic [19:0]        in_elapsed_us,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic signed [16:0] out_vel_x,
  output logic signed [16:0] out_vel_y,
  output logic signed [15:0] out_turn_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_half_axle_mm
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ddo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_left_speed    (in_left_speed),
    .in_right_speed   (in_right_speed),
    .in_elapsed_us    (in_elapsed_us),
    .in_pose_x        (in_pose_x),
    .in_pose_y        (in_pose_y),
    .in_pose_yaw      (in_pose_yaw),
    .cfg_valid        (cfg_valid),
    .cfg_half_axle_mm (cfg_half_axle_mm),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_vel_x        (out_vel_x),
    .out_vel_y        (out_vel_y),
    .out_turn_rate    (out_turn_rate)
  );

endmodule

@@ src/ddo_ctrl.sv @@
module ddo_ctrl import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_stall,
  input  logic    out_stall,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_ITERS - 1);
  localparam logic [CNT_W-1:0] COR_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.mul_sel = MUL_RATE;
    cmd.wb_sel  = WB_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_op ? ST_FIN : ST_R_MUL;
        end
      end
      ST_R_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RATE; state_nxt = ST_R_LD;
      end
      ST_R_LD: begin
        cmd.div_load = 1'b1; cmd.div_rate = 1'b1; cnt_nxt = '0; state_nxt = ST_R_DIV;
      end
      ST_R_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_R_WB;
      end
      ST_R_WB: begin
        cmd.wb_sel = WB_RATE; state_nxt = ST_W_MUL;
      end
      ST_W_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_YAW; state_nxt = ST_W_LD;
      end
      ST_W_LD: begin
        cmd.div_load = 1'b1; state_nxt = ST_W_DIV;
      end
      ST_W_DIV: begin
        cmd.rcp_step = 1'b1; state_nxt = ST_W_WB;
      end
      ST_W_WB: begin
        cmd.wb_sel = WB_YAW; state_nxt = ST_C_INIT;
      end
      ST_C_INIT: begin
        cmd.cordic_init = 1'b1; cnt_nxt = '0; state_nxt = ST_C_ITER;
      end
      ST_C_ITER: begin
        cmd.cordic_step = 1'b1;
        cmd.cordic_idx  = cnt_r[4:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == COR_LAST) state_nxt = ST_C_FIX;
      end
      ST_C_FIX: begin
        cmd.cordic_fix = 1'b1; state_nxt = ST_VX_MUL;
      end
      ST_VX_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_VX; state_nxt = ST_VX_WB;
      end
      ST_VX_WB: begin
        cmd.wb_sel = WB_VX; state_nxt = ST_VY_MUL;
      end
      ST_VY_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_VY; state_nxt = ST_VY_WB;
      end
      ST_VY_WB: begin
        cmd.wb_sel = WB_VY; state_nxt = ST_X_MUL;
      end
      ST_X_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PX; state_nxt = ST_X_LD;
      end
      ST_X_LD: begin
        cmd.div_load = 1'b1; state_nxt = ST_X_DIV;
      end
      ST_X_DIV: begin
        cmd.rcp_step = 1'b1; state_nxt = ST_X_WB;
      end
      ST_X_WB: begin
        cmd.wb_sel = WB_X; state_nxt = ST_Y_MUL;
      end
      ST_Y_MUL: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = MUL_PY; state_nxt = ST_Y_LD;
      end
      ST_Y_LD: begin
        cmd.div_load = 1'b1; state_nxt = ST_Y_DIV;
      end
      ST_Y_DIV: begin
        cmd.rcp_step = 1'b1; state_nxt = ST_Y_WB;
      end
      ST_Y_WB: begin
        cmd.wb_sel = WB_Y; state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // output register must be free before the result is written
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

`ifndef SYNTH
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result not presented after finish");
  a_pose_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_op) |=> state_r == ST_FIN)
    else $error("set pose did not go straight to finish");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_R_DIV) |-> cnt_r <= DIV_LAST)
    else $error("divider count overrun");
  a_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("pending result overwritten");
`endif

endmodule

@@ src/ddo_dp.sv @@
module ddo_dp import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic               in_op,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  input  logic [19:0]        in_elapsed_us,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_yaw,
  input  logic               cfg_valid,
  input  logic [10:0]        cfg_half_axle_mm,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic signed [16:0] out_vel_x,
  output logic signed [16:0] out_vel_y,
  output logic signed [15:0] out_turn_rate
);

  logic [10:0]        axle_r;
  logic signed [31:0] x_r, y_r;
  logic signed [15:0] yaw_r, rate_r;
  logic signed [16:0] vx_r, vy_r, sum_r, diff_r;
  logic [19:0]        dt_r;
  logic signed [52:0] prod_r;
  logic [47:0]        dvd_r;
  logic [32:0]        rem_r;
  logic [31:0]        dsr_r;
  logic               neg_r;
  logic [30:0]        rcp_src_r;
  logic [62:0]        rcp_prod_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) axle_r <= HALF_AXLE_RST;
    else if (cfg_valid) axle_r <= cfg_half_axle_mm;
  end

  // shared multiplier
  logic signed [17:0] ma;
  logic signed [34:0] mb;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RATE: begin ma = {diff_r[16], diff_r};   mb = RAD2BAM; end
      MUL_YAW:  begin ma = 18'(rate_r);            mb = {15'b0, dt_r}; end
      MUL_VX:   begin ma = {sum_r[16], sum_r};     mb = {cx_r[33], cx_r}; end
      MUL_VY:   begin ma = {sum_r[16], sum_r};     mb = {cy_r[33], cy_r}; end
      MUL_PX:   begin ma = {vx_r[16], vx_r};       mb = {15'b0, dt_r}; end
      MUL_PY:   begin ma = {vy_r[16], vy_r};       mb = {15'b0, dt_r}; end
      default:  begin ma = '0;                     mb = '0; end
    endcase
  end

  // divisor and rounding half; rate divisor is len * 20 * 65536
  logic [10:0] len;
  logic [31:0] dsr_sel, half_sel;
  logic [47:0] num, mag;
  assign len      = (axle_r == '0) ? 11'd1 : axle_r;
  assign dsr_sel  = (32'(len) << 20) + (32'(len) << 18);
  assign half_sel = cmd.div_rate ? ((32'(len) << 19) + (32'(len) << 17)) : US_HALF;
  assign num      = prod_r[47:0] + {16'b0, half_sel};
  assign mag      = num[47] ? ~num : num;

  // restoring divider step; floor of a negative n is ~(~n / d)
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [47:0] quo_mag, quo;
  assign rem_sh  = {rem_r[31:0], dvd_r[47]};
  assign q_bit   = (rem_sh >= {1'b0, dsr_r});
  // divide by 10^6: mag stays below 2^37, so mag >> 6 fits 31 bits
  assign quo_mag = (cmd.wb_sel == WB_RATE) ? dvd_r : {30'b0, rcp_prod_r[62:45]};
  assign quo     = neg_r ? ~quo_mag : quo_mag;

  // velocity round and saturate
  logic signed [52:0] vt;
  logic signed [21:0] vr;
  logic signed [16:0] vsat;
  assign vt = prod_r + 53'sd1073741824;
  assign vr = vt[52:31];
  always_comb begin
    if (vr > 22'sd65535)       vsat = 17'sd65535;
    else if (vr < -22'sd65536) vsat = -17'sd65536;
    else                       vsat = vr[16:0];
  end

  // position update with saturation
  logic signed [32:0] psum;
  logic signed [31:0] pbase, psat;
  assign pbase = (cmd.wb_sel == WB_X) ? x_r : y_r;
  assign psum  = {pbase[31], pbase} + {{9{quo[23]}}, quo[23:0]};
  always_comb begin
    if (psum[32] != psum[31]) psat = psum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                      psat = psum[31:0];
  end

  // CORDIC
  logic [31:0]        ang;
  logic               fl;
  logic signed [33:0] dx, dy, at;
  assign ang = {yaw_r, 16'b0};
  assign fl  = ang[31] ^ ang[30];
  assign dx  = cy_r >>> cmd.cordic_idx;
  assign dy  = cx_r >>> cmd.cordic_idx;
  assign at  = {2'b0, atan_turn(cmd.cordic_idx)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0; y_r <= '0; yaw_r <= '0;
    end else begin
      if (cmd.load_in && in_op) begin
        x_r <= in_pose_x; y_r <= in_pose_y; yaw_r <= in_pose_yaw;
      end
      unique case (cmd.wb_sel)
        WB_YAW:  yaw_r <= yaw_r + quo[15:0];
        WB_X:    x_r   <= psat;
        WB_Y:    y_r   <= psat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r   <= in_elapsed_us;
      sum_r  <= {in_left_speed[15], in_left_speed} + {in_right_speed[15], in_right_speed};
      diff_r <= {in_right_speed[15], in_right_speed} - {in_left_speed[15], in_left_speed};
      if (in_op) begin
        vx_r <= '0; vy_r <= '0; rate_r <= '0;
      end
    end
    unique case (cmd.wb_sel)
      WB_RATE: rate_r <= quo[15:0];
      WB_VX:   vx_r   <= vsat;
      WB_VY:   vy_r   <= vsat;
      default: ;
    endcase
    if (cmd.mul_en) prod_r <= ma * mb;
    if (cmd.div_load) begin
      neg_r     <= num[47];
      dvd_r     <= mag;
      dsr_r     <= dsr_sel;
      rem_r     <= '0;
      rcp_src_r <= mag[36:6];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      dvd_r <= {dvd_r[46:0], q_bit};
    end
    if (cmd.rcp_step) rcp_prod_r <= rcp_src_r * RCP_15625;
    if (cmd.cordic_init) begin
      flip_r <= fl;
      cx_r   <= CORDIC_GAIN;
      cy_r   <= '0;
      cz_r   <= {{2{ang[31] ^ fl}}, ang[31] ^ fl, ang[30:0]};
    end else if (cmd.cordic_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + at;
      end
    end else if (cmd.cordic_fix && flip_r) begin
      cx_r <= -cx_r;
      cy_r <= -cy_r;
    end
    if (cmd.emit) begin
      out_pos_x     <= x_r;
      out_pos_y     <= y_r;
      out_heading   <= yaw_r;
      out_vel_x     <= vx_r;
      out_vel_y     <= vy_r;
      out_turn_rate <= rate_r;
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ddo_pkg::*;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hd;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [15:0] tr;
  } pose_res_t;

  localparam longint GAIN_Q30 = 652032874;
  localparam longint BAM_PER_RAD = 683565276;
  localparam longint USEC = 1000000;
  localparam int N_STEPS = CORDIC_STEPS_DEF;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_UPDATE;
  logic signed [15:0] in_left_speed = '0;
  logic signed [15:0] in_right_speed = '0;
  logic [19:0] in_elapsed_us = '0;
  logic signed [31:0] in_pose_x = '0;
  logic signed [31:0] in_pose_y = '0;
  logic signed [15:0] in_pose_yaw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic signed [15:0] out_heading, out_turn_rate;
  logic signed [16:0] out_vel_x, out_vel_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_half_axle_mm = '0;

  diff_drive_odometry_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_left_speed(in_left_speed), .in_right_speed(in_right_speed),
    .in_elapsed_us(in_elapsed_us), .in_pose_x(in_pose_x), .in_pose_y(in_pose_y),
    .in_pose_yaw(in_pose_yaw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_turn_rate(out_turn_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_half_axle_mm(cfg_half_axle_mm)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint track_half = 150;
  longint est_x = 0, est_y = 0, est_yaw = 0;
  pose_res_t pose_q[$];
  longint atan_tab[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544,
    333772, 166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  int mismatches = 0;
  int n_items = 0, n_results = 0, n_cfg = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint div_round(longint n, longint d);
    return div_floor(n + d / 2, d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_bam(longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  task automatic heading_cos_sin(input longint yaw, output longint c, output longint s);
    logic [31:0] a;
    logic signed [31:0] zs;
    bit flip;
    longint x, y, z, dx, dy;
    a = {yaw[15:0], 16'h0};
    flip = (a[31:30] == 2'd1 || a[31:30] == 2'd2);
    if (flip) a = a ^ 32'h8000_0000;
    zs = a;
    z = zs;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < N_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic predict_pose(input logic op, input longint vl, input longint vr,
                              input longint dt, input longint px, input longint py,
                              input longint pyaw);
    pose_res_t r;
    longint vx, vy, rate, len, c, s;
    vx = 0; vy = 0; rate = 0;
    if (op == OP_SET_POSE) begin
      est_x = px; est_y = py; est_yaw = pyaw;
    end else begin
      len = track_half ? track_half : 1;
      rate = wrap_bam(div_round((vr - vl) * BAM_PER_RAD, 2 * len * 10 * 65536));
      est_yaw = wrap_bam(est_yaw + div_round(rate * dt, USEC));
      heading_cos_sin(est_yaw, c, s);
      vx = clamp(div_round((vl + vr) * c, 64'sd1 <<< 31), -65536, 65535);
      vy = clamp(div_round((vl + vr) * s, 64'sd1 <<< 31), -65536, 65535);
      est_x = clamp(est_x + div_round(vx * dt, USEC), -64'sd2147483648, 64'sd2147483647);
      est_y = clamp(est_y + div_round(vy * dt, USEC), -64'sd2147483648, 64'sd2147483647);
    end
    r.px = est_x[31:0]; r.py = est_y[31:0]; r.hd = est_yaw[15:0];
    r.vx = vx[16:0]; r.vy = vy[16:0]; r.tr = rate[15:0];
    pose_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  task automatic send_item(input logic op, input logic signed [15:0] vl,
                           input logic signed [15:0] vr, input logic [19:0] dt,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [15:0] pyaw);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op; in_left_speed = vl; in_right_speed = vr; in_elapsed_us = dt;
    in_pose_x = px; in_pose_y = py; in_pose_yaw = pyaw;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_pose(op, vl, vr, dt, px, py, pyaw);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (N_STEPS + 240) @(posedge clk);
  endtask

  task automatic write_half_axle(input logic [10:0] v);
    drain();
    @(negedge clk);
    cfg_half_axle_mm = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    track_half = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_update(input int spread);
    logic signed [15:0] vl, vr, base;
    logic [19:0] dt;
    if (spread == 0) begin
      vl = 16'($urandom); vr = 16'($urandom);
    end else begin
      base = 16'($urandom_range(0, 40000) - 20000);
      vl = 16'(base + $urandom_range(0, 2 * spread) - spread);
      vr = 16'(base + $urandom_range(0, 2 * spread) - spread);
    end
    dt = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 200000));
    send_item(OP_UPDATE, vl, vr, dt, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic send_random_pose();
    logic signed [31:0] px, py;
    case ($urandom_range(0, 3))
      0: begin px = $urandom; py = $urandom; end
      1: begin px = 32'sh7fff_0000 + $urandom_range(0, 65535); py = -px; end
      default: begin px = $urandom_range(0, 2000000) - 1000000; py = $urandom_range(0, 2000000) - 1000000; end
    endcase
    send_item(OP_SET_POSE, 16'($urandom), 16'($urandom), 20'($urandom), px, py,
              16'($urandom));
  endtask

  // result stall generator
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
      case ($urandom_range(0, 29))
        0, 1, 2, 3: stall_left = $urandom_range(1, 4);
        4: stall_left = $urandom_range(20, 80);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    pose_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        e = pose_q.pop_front();
        if (out_pos_x !== e.px || out_pos_y !== e.py || out_heading !== e.hd ||
            out_vel_x !== e.vx || out_vel_y !== e.vy || out_turn_rate !== e.tr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%0d y=%0d hd=%0d vx=%0d vy=%0d tr=%0d, got x=%0d y=%0d hd=%0d vx=%0d vy=%0d tr=%0d",
                     n_results, e.px, e.py, e.hd, e.vx, e.vy, e.tr, out_pos_x, out_pos_y,
                     out_heading, out_vel_x, out_vel_y, out_turn_rate);
        end
      end
    end
  end

  task automatic test_reset_pose();
    send_item(OP_UPDATE, 16'sd0, 16'sd0, 20'd0, 0, 0, 0);
    send_item(OP_UPDATE, 16'sd1000, 16'sd1000, 20'd100000, 0, 0, 0);
  endtask

  task automatic test_directed_extremes();
    send_item(OP_UPDATE, 16'sh7fff, 16'sh7fff, 20'hfffff, 0, 0, 0);
    send_item(OP_UPDATE, -16'sh8000, -16'sh8000, 20'hfffff, 0, 0, 0);
    send_item(OP_UPDATE, -16'sh8000, 16'sh7fff, 20'hfffff, 0, 0, 0);
    send_item(OP_UPDATE, 16'sh7fff, -16'sh8000, 20'd0, 0, 0, 0);
    // the quadrant boundaries and headings in the first and second quadrants
    send_item(OP_SET_POSE, 0, 0, 0, 32'sh7fff_ffff, -32'sh8000_0000, 16'sd16384);
    send_item(OP_UPDATE, 16'sd20000, 16'sd20000, 20'd500000, 0, 0, 0);
    send_item(OP_SET_POSE, 0, 0, 0, -32'sh8000_0000, 32'sh7fff_ffff, -16'sd16384);
    send_item(OP_UPDATE, 16'sd20000, 16'sd20000, 20'd500000, 0, 0, 0);
    send_item(OP_SET_POSE, 0, 0, 0, 32'sh7fff_fff0, 32'sh7fff_fff0, -16'sh8000);
    send_item(OP_UPDATE, -16'sh8000, -16'sh8000, 20'hfffff, 0, 0, 0);
    send_item(OP_SET_POSE, 0, 0, 0, -32'sh7fff_fff0, -32'sh7fff_fff0, 16'sh7fff);
    send_item(OP_UPDATE, 16'sh7fff, 16'sh7fff, 20'hfffff, 0, 0, 0);
    send_item(OP_SET_POSE, -1, -1, -1, 0, 0, 16'sd8192);
    send_item(OP_UPDATE, 16'sd32000, 16'sd32000, 20'd1, 0, 0, 0);
  endtask

  task automatic test_half_axle_edges();
    logic [10:0] vals[4] = '{11'd0, 11'd1, 11'd2000, 11'h7ff};
    foreach (vals[k]) begin
      write_half_axle(vals[k]);
      send_item(OP_UPDATE, -16'sh8000, 16'sh7fff, 20'hfffff, 0, 0, 0);
      send_item(OP_UPDATE, 16'sd300, -16'sd300, 20'd12345, 0, 0, 0);
    end
  endtask

  task automatic test_random_traffic();
    logic [10:0] axle;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: axle = 11'd1;
        1: axle = 11'd2000;
        2: axle = 11'd150;
        3: axle = 11'h7ff;
        default: axle = 11'($urandom_range(0, 2047));
      endcase
      write_half_axle(axle);
      quiet = (ph == 5);
      for (int k = 0; k < 105; k++) begin
        if ($urandom_range(0, 9) == 0) send_random_pose();
        else send_random_update($urandom_range(0, 1) ? 0 : $urandom_range(1, 500));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_pose();
    test_directed_extremes();
    test_half_axle_edges();
    test_random_traffic();
    drain();
    $display("Covered %0d input transactions, %0d results, %0d half-axle writes,",
             n_items, n_results, n_cfg);
    $display("set-pose and update mixes under random stalls on both sides.");
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pose_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
